@@ hdl/hvd_pkg.sv @@
// Shared constants, widths and the arctangent table for the haversine distance pipeline.
package hvd_pkg;

    localparam int CORDIC_STEPS    = 32;
    localparam int ANGLE_FRAC_BITS = 28;
    localparam int SQRT_STEPS      = 32;

    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int DIST_W = 35;

    localparam int E7_W   = LON_W + 1;
    localparam int PROD_W = E7_W + 32;
    localparam int SUM_W  = PROD_W + 1;
    localparam int ANG_W  = ANGLE_FRAC_BITS + 4;
    localparam int XY_W   = 33;
    localparam int SQ_W   = 2 * XY_W;
    localparam int T_W    = 34;
    localparam int P2_W   = 2 * T_W;
    localparam int A_W    = 32;
    localparam int N_W    = 63;
    localparam int AT_W   = 35;
    localparam int C29_W  = 32;
    localparam int MMP_W  = C29_W + 33;
    localparam int MM_W   = MMP_W + 1;

    localparam int SHIFT_HALF = 62 - ANGLE_FRAC_BITS;
    localparam int SHIFT_FULL = 61 - ANGLE_FRAC_BITS;

    localparam logic [63:0] PI_Q61     = 64'h6487_ED51_10B4_611A;
    localparam logic [31:0] RAD_PER_E7 = 32'(PI_Q61 / 64'd1800000000);

    localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (SHIFT_HALF - 1);
    localparam logic [SUM_W-1:0] RND_FULL = SUM_W'(1) << (SHIFT_FULL - 1);

    localparam logic signed [ANG_W-1:0] PI_ANG =
        ANG_W'((PI_Q61 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS));
    localparam logic signed [ANG_W-1:0] NEG_PI_ANG  = -PI_ANG;
    localparam logic signed [ANG_W-1:0] TWO_PI_ANG  = PI_ANG <<< 1;
    localparam logic signed [ANG_W-1:0] HALF_PI_ANG = PI_ANG >>> 1;
    localparam logic signed [ANG_W-1:0] NEG_HALF_PI_ANG = -HALF_PI_ANG;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = XY_W'(64'sd652032874);

    localparam logic [A_W-1:0]    A_ONE           = 32'h8000_0000;
    localparam logic [32:0]       EARTH_RADIUS_MM = 33'd6371000000;
    localparam logic [DIST_W-1:0] DIST_MAX        = 35'd20015087000;

    localparam int SC_LAT   = CORDIC_STEPS + 7;
    localparam int PIPE_LAT = 1 + SC_LAT + 5 + SQRT_STEPS + CORDIC_STEPS + 3;
    localparam int VLD_A    = SC_LAT + 5;

    function automatic logic [CORDIC_STEPS-1:0][ANG_W-1:0] atan_table();
        logic [CORDIC_STEPS-1:0][ANG_W-1:0] tab;
        logic [63:0] acc;
        logic [63:0] term;
        int          p;
        tab = '0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            acc = '0;
            if (i == 0)
            begin
                acc = PI_Q61 >> 1;
            end
            else
            begin
                for (int k = 0; k < 32; k++)
                begin
                    p = i * (2 * k + 1);
                    if (p <= 62)
                    begin
                        term = (64'd1 << (62 - p)) / 64'(2 * k + 1);
                        if ((k % 2) != 0)
                        begin
                            acc = acc - term;
                        end
                        else
                        begin
                            acc = acc + term;
                        end
                    end
                end
            end
            tab[i] = ANG_W'((acc + (64'd1 << (61 - ANGLE_FRAC_BITS)))
                            >> (62 - ANGLE_FRAC_BITS));
        end
        return tab;
    endfunction

    localparam logic [CORDIC_STEPS-1:0][ANG_W-1:0] ATAN_TAB = atan_table();

endpackage

@@ hdl/hvd_pos_if.sv @@
// Request channel carrying the two positions.
interface hvd_pos_if;
    import hvd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] first_lat;
    logic signed [LON_W-1:0] first_lon;
    logic signed [LAT_W-1:0] second_lat;
    logic signed [LON_W-1:0] second_lon;

    modport source (
        output valid, first_lat, first_lon, second_lat, second_lon,
        input  ready
    );

    modport sink (
        input  valid, first_lat, first_lon, second_lat, second_lon,
        output ready
    );
endinterface

@@ hdl/hvd_dist_if.sv @@
// Result channel carrying the distance in millimetres.
interface hvd_dist_if;
    import hvd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance_mm;

    modport source (
        output valid, distance_mm,
        input  ready
    );

    modport sink (
        input  valid, distance_mm,
        output ready
    );
endinterface

@@ hdl/hvd_sincos.sv @@
// Pipelined conversion from 1e-7 degree to radians followed by a rotation CORDIC.
module hvd_sincos (
    input  logic                            clk,
    input  logic                            ce,
    input  logic                            half,
    input  logic signed [hvd_pkg::E7_W-1:0] e7,
    output logic signed [hvd_pkg::XY_W-1:0] sin_q30,
    output logic signed [hvd_pkg::XY_W-1:0] cos_q30
);
    import hvd_pkg::*;

    logic [E7_W-1:0]          mag_reg, mag_next;
    logic                     neg0_reg;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic                     neg1_reg;
    logic signed [ANG_W-1:0]  ang_reg, ang_next;
    logic signed [ANG_W-1:0]  wa_reg, wa_next;
    logic signed [ANG_W-1:0]  wb_reg, wb_next;
    logic signed [ANG_W-1:0]  z0_reg, z0_next;
    logic                     flip0_reg, flip0_next;
    logic [SUM_W-1:0]         rnd_h, rnd_f;
    logic [ANG_W-1:0]         ang_mag;
    logic signed [ANG_W-1:0]  wa_tmp, wb_tmp;

    logic signed [XY_W-1:0]   x_reg [CORDIC_STEPS];
    logic signed [XY_W-1:0]   y_reg [CORDIC_STEPS];
    logic signed [ANG_W-1:0]  z_reg [CORDIC_STEPS];
    logic                     flip_reg [CORDIC_STEPS];
    logic signed [XY_W-1:0]   x_next [CORDIC_STEPS];
    logic signed [XY_W-1:0]   y_next [CORDIC_STEPS];
    logic signed [ANG_W-1:0]  z_next [CORDIC_STEPS];

    logic signed [XY_W-1:0]   sin_reg, cos_reg;
    logic signed [XY_W-1:0]   sin_next, cos_next;

    always_comb
    begin
        mag_next  = e7[E7_W-1] ? E7_W'(-e7) : E7_W'(e7);
        prod_next = PROD_W'(mag_reg) * PROD_W'(RAD_PER_E7);
        rnd_h     = SUM_W'(prod_reg) + RND_HALF;
        rnd_f     = SUM_W'(prod_reg) + RND_FULL;
        ang_mag   = half ? ANG_W'(rnd_h >> SHIFT_HALF) : ANG_W'(rnd_f >> SHIFT_FULL);
        ang_next  = neg1_reg ? -signed'(ang_mag) : signed'(ang_mag);
    end

    always_comb
    begin
        wa_tmp  = (ang_reg > PI_ANG) ? ang_reg - TWO_PI_ANG : ang_reg;
        wa_next = (wa_tmp > PI_ANG) ? wa_tmp - TWO_PI_ANG : wa_tmp;
        wb_tmp  = (wa_reg < NEG_PI_ANG) ? wa_reg + TWO_PI_ANG : wa_reg;
        wb_next = (wb_tmp < NEG_PI_ANG) ? wb_tmp + TWO_PI_ANG : wb_tmp;
    end

    // Folding into the right half-plane negates the cosine.
    always_comb
    begin
        z0_next    = wb_reg;
        flip0_next = 1'b0;
        if (wb_reg > HALF_PI_ANG)
        begin
            z0_next    = PI_ANG - wb_reg;
            flip0_next = 1'b1;
        end
        else if (wb_reg < NEG_HALF_PI_ANG)
        begin
            z0_next    = NEG_PI_ANG - wb_reg;
            flip0_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mag_reg   <= mag_next;
            neg0_reg  <= e7[E7_W-1];
            prod_reg  <= prod_next;
            neg1_reg  <= neg0_reg;
            ang_reg   <= ang_next;
            wa_reg    <= wa_next;
            wb_reg    <= wb_next;
            z0_reg    <= z0_next;
            flip0_reg <= flip0_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [ANG_W-1:0] ATAN_I = ATAN_TAB[i];
        logic signed [XY_W-1:0]  xi, yi;
        logic signed [ANG_W-1:0] zi;
        logic                    fi;

        if (i == 0)
        begin : g_first
            assign xi = CORDIC_GAIN_Q30;
            assign yi = '0;
            assign zi = z0_reg;
            assign fi = flip0_reg;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign fi = flip_reg[i-1];
        end

        always_comb
        begin
            if (!zi[ANG_W-1])
            begin
                x_next[i] = xi - (yi >>> i);
                y_next[i] = yi + (xi >>> i);
                z_next[i] = zi - ATAN_I;
            end
            else
            begin
                x_next[i] = xi + (yi >>> i);
                y_next[i] = yi - (xi >>> i);
                z_next[i] = zi + ATAN_I;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                x_reg[i]    <= x_next[i];
                y_reg[i]    <= y_next[i];
                z_reg[i]    <= z_next[i];
                flip_reg[i] <= fi;
            end
        end
    end

    assign sin_next = y_reg[CORDIC_STEPS-1];
    assign cos_next = flip_reg[CORDIC_STEPS-1] ? -x_reg[CORDIC_STEPS-1]
                                                : x_reg[CORDIC_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

@@ hdl/haversine_distance.sv @@
// Haversine great-circle distance pipeline, top level.
//
//  channel | direction | payload
//  pos     | sink      | first_lat, first_lon, second_lat, second_lon
//  result  | source    | distance_mm
//
// One request is taken every cycle unless a result waits untaken. The four rotation CORDIC
// units run side by side, followed by the two 32-step square roots and the vectoring CORDIC,
// each of which spends one register stage on every step.
// Reset clears only the valid bits that travel alongside the data.
// When a result waits untaken the whole pipeline holds, so nothing is dropped or repeated.
module haversine_distance (
    input  logic      clk,
    input  logic      rst_n,
    hvd_pos_if.sink   pos,
    hvd_dist_if.source result
);
    import hvd_pkg::*;

    logic                    ce;
    logic [PIPE_LAT-1:0]     vld_reg, vld_next;

    logic signed [E7_W-1:0]  dlat_reg, dlat_next;
    logic signed [E7_W-1:0]  dlon_reg, dlon_next;
    logic signed [E7_W-1:0]  lat1_reg, lat2_reg;

    logic signed [XY_W-1:0]  s1, s2, c1, c2;

    logic signed [SQ_W-1:0]  s1sq_reg, s1sq_next;
    logic signed [SQ_W-1:0]  s2sq_raw_reg, s2sq_raw_next;
    logic signed [SQ_W-1:0]  c12_raw_reg, c12_raw_next;
    logic signed [T_W-1:0]   t1_reg, t1_next;
    logic signed [T_W-1:0]   s2sq_reg, s2sq_next;
    logic signed [T_W-1:0]   c12_reg, c12_next;
    logic signed [P2_W-1:0]  prod2_reg, prod2_next;
    logic signed [T_W-1:0]   t1b_reg, t1c_reg;
    logic signed [T_W-1:0]   t2_reg, t2_next;
    logic signed [T_W:0]     a_sum;
    logic [A_W-1:0]          a_reg, a_next;

    localparam logic signed [T_W:0] A_ONE_S = (T_W+1)'(64'sd2147483648);

    logic [N_W-1:0]          sqn_reg [SQRT_STEPS][2];
    logic [N_W-1:0]          sqr_reg [SQRT_STEPS][2];
    logic [N_W-1:0]          sqn_next [SQRT_STEPS][2];
    logic [N_W-1:0]          sqr_next [SQRT_STEPS][2];
    logic [N_W-1:0]          sq_init [2];
    logic [A_W-1:0]          sa, sb;

    logic signed [AT_W-1:0]  ax_reg [CORDIC_STEPS];
    logic signed [AT_W-1:0]  ay_reg [CORDIC_STEPS];
    logic signed [ANG_W-1:0] az_reg [CORDIC_STEPS];
    logic signed [AT_W-1:0]  ax_next [CORDIC_STEPS];
    logic signed [AT_W-1:0]  ay_next [CORDIC_STEPS];
    logic signed [ANG_W-1:0] az_next [CORDIC_STEPS];

    logic signed [ANG_W-1:0] zf, zpos;
    logic [C29_W-1:0]        c29_reg, c29_next;
    logic [MMP_W-1:0]        mmp_reg, mmp_next;
    logic [MM_W-1:0]         mm;
    logic [DIST_W-1:0]       dist_reg, dist_next;

    assign ce        = !result.valid || result.ready;
    assign pos.ready = ce;

    assign vld_next = {vld_reg[PIPE_LAT-2:0], pos.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= vld_next;
        end
    end

    assign dlat_next = E7_W'(pos.second_lat) - E7_W'(pos.first_lat);
    assign dlon_next = E7_W'(pos.second_lon) - E7_W'(pos.first_lon);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dlat_reg <= dlat_next;
            dlon_reg <= dlon_next;
            lat1_reg <= E7_W'(pos.first_lat);
            lat2_reg <= E7_W'(pos.second_lat);
        end
    end

    hvd_sincos u_dlat (
        .clk     (clk),
        .ce      (ce),
        .half    (1'b1),
        .e7      (dlat_reg),
        .sin_q30 (s1),
        .cos_q30 ()
    );

    hvd_sincos u_dlon (
        .clk     (clk),
        .ce      (ce),
        .half    (1'b1),
        .e7      (dlon_reg),
        .sin_q30 (s2),
        .cos_q30 ()
    );

    hvd_sincos u_lat1 (
        .clk     (clk),
        .ce      (ce),
        .half    (1'b0),
        .e7      (lat1_reg),
        .sin_q30 (),
        .cos_q30 (c1)
    );

    hvd_sincos u_lat2 (
        .clk     (clk),
        .ce      (ce),
        .half    (1'b0),
        .e7      (lat2_reg),
        .sin_q30 (),
        .cos_q30 (c2)
    );

    always_comb
    begin
        s1sq_next     = SQ_W'(s1) * SQ_W'(s1);
        s2sq_raw_next = SQ_W'(s2) * SQ_W'(s2);
        c12_raw_next  = SQ_W'(c1) * SQ_W'(c2);
        t1_next       = T_W'((s1sq_reg + SQ_W'(64'sd268435456)) >>> 29);
        s2sq_next     = T_W'((s2sq_raw_reg + SQ_W'(64'sd536870912)) >>> 30);
        c12_next      = T_W'((c12_raw_reg + SQ_W'(64'sd536870912)) >>> 30);
        prod2_next    = P2_W'(c12_reg) * P2_W'(s2sq_reg);
        t2_next       = T_W'((prod2_reg + P2_W'(64'sd268435456)) >>> 29);
        a_sum         = (T_W+1)'(t1c_reg) + (T_W+1)'(t2_reg);
        if (a_sum[T_W])
        begin
            a_next = '0;
        end
        else if (a_sum > A_ONE_S)
        begin
            a_next = A_ONE;
        end
        else
        begin
            a_next = A_W'(a_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1sq_reg     <= s1sq_next;
            s2sq_raw_reg <= s2sq_raw_next;
            c12_raw_reg  <= c12_raw_next;
            t1_reg       <= t1_next;
            s2sq_reg     <= s2sq_next;
            c12_reg      <= c12_next;
            prod2_reg    <= prod2_next;
            t1b_reg      <= t1_reg;
            t2_reg       <= t2_next;
            t1c_reg      <= t1b_reg;
            a_reg        <= a_next;
        end
    end

    // Lane zero takes the root of a, lane one the root of one minus a.
    assign sq_init[0] = N_W'({a_reg, 31'd0});
    assign sq_init[1] = N_W'({A_ONE - a_reg, 31'd0});

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [N_W-1:0] BIT_K = N_W'(1) << (62 - 2 * k);
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [N_W-1:0] ni, ri;
            logic [N_W:0]   trial;

            if (k == 0)
            begin : g_first
                assign ni = sq_init[l];
                assign ri = '0;
            end
            else
            begin : g_rest
                assign ni = sqn_reg[k-1][l];
                assign ri = sqr_reg[k-1][l];
            end

            always_comb
            begin
                trial = (N_W+1)'(ri) + (N_W+1)'(BIT_K);
                if ((N_W+1)'(ni) >= trial)
                begin
                    sqn_next[k][l] = N_W'((N_W+1)'(ni) - trial);
                    sqr_next[k][l] = (ri >> 1) + BIT_K;
                end
                else
                begin
                    sqn_next[k][l] = ni;
                    sqr_next[k][l] = ri >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    sqn_reg[k][l] <= sqn_next[k][l];
                    sqr_reg[k][l] <= sqr_next[k][l];
                end
            end
        end
    end

    assign sa = A_W'(sqr_reg[SQRT_STEPS-1][0]);
    assign sb = A_W'(sqr_reg[SQRT_STEPS-1][1]);

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_atan
        localparam logic signed [ANG_W-1:0] ATAN_I = ATAN_TAB[i];
        logic signed [AT_W-1:0]  xi, yi;
        logic signed [ANG_W-1:0] zi;

        if (i == 0)
        begin : g_first
            assign xi = AT_W'(sb);
            assign yi = AT_W'(sa);
            assign zi = '0;
        end
        else
        begin : g_rest
            assign xi = ax_reg[i-1];
            assign yi = ay_reg[i-1];
            assign zi = az_reg[i-1];
        end

        always_comb
        begin
            if (!yi[AT_W-1] && (yi != '0))
            begin
                ax_next[i] = xi + (yi >>> i);
                ay_next[i] = yi - (xi >>> i);
                az_next[i] = zi + ATAN_I;
            end
            else
            begin
                ax_next[i] = xi - (yi >>> i);
                ay_next[i] = yi + (xi >>> i);
                az_next[i] = zi - ATAN_I;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                ax_reg[i] <= ax_next[i];
                ay_reg[i] <= ay_next[i];
                az_reg[i] <= az_next[i];
            end
        end
    end

    assign zf   = az_reg[CORDIC_STEPS-1];
    assign zpos = zf[ANG_W-1] ? '0 : zf;

    // The central angle is twice the arctangent, hence one extra bit of shift.
    if (ANGLE_FRAC_BITS > 30)
    begin : g_c29_down
        localparam int SH = ANGLE_FRAC_BITS - 30;
        assign c29_next = C29_W'((zpos + (ANG_W'(1) << (SH - 1))) >> SH);
    end
    else
    begin : g_c29_up
        localparam int SH = 30 - ANGLE_FRAC_BITS;
        assign c29_next = C29_W'(zpos) << SH;
    end

    always_comb
    begin
        mmp_next = MMP_W'(c29_reg) * MMP_W'(EARTH_RADIUS_MM);
        mm       = (MM_W'(mmp_reg) + (MM_W'(1) << 28)) >> 29;
        if (mm > MM_W'(DIST_MAX))
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = DIST_W'(mm);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            c29_reg  <= c29_next;
            mmp_reg  <= mmp_next;
            dist_reg <= dist_next;
        end
    end

    assign result.valid       = vld_reg[PIPE_LAT-1];
    assign result.distance_mm = dist_reg;

`ifndef SYNTHESIS
    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.distance_mm <= DIST_MAX))
        else $error("Distance exceeds half the circumference.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable(vld_reg))
        else $error("Valid bits moved while the pipeline was stalled.");

    a_a_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[VLD_A] |-> (a_reg <= A_ONE))
        else $error("Haversine term left the unit interval.");
`endif

endmodule
